>>> rtl/cwpg_pkg.sv
package cwpg_pkg;

   localparam int INDEX_BITS     = 28;
   localparam int WINDOW_BITS    = 4;
   localparam int DIST_BITS      = 5;
   localparam int HIST_DEPTH     = 8;
   localparam int HIST_PTR_BITS  = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   typedef logic [WINDOW_BITS-1:0] window_type;

   localparam window_type MAX_WINDOW   = 4'd8;
   localparam window_type WINDOW_RESET = 4'd4;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_WINDOW_LEFT  = 2'd0;
   localparam csr_index_type CSR_WINDOW_RIGHT = 2'd1;

   // one classified word on its way from the front to the back
   typedef struct packed {
      logic [INDEX_BITS-1:0] word;
      window_type            start_dist;
      window_type            win_left;
      window_type            win_right;
   } job_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } back_state_type;

endpackage

>>> rtl/cwpg_req_if.sv
interface cwpg_req_if;
   logic                              valid;
   logic                              ready;
   logic [cwpg_pkg::INDEX_BITS-1:0]   word_index;

   modport source (output valid, output word_index, input ready);
   modport sink (input valid, input word_index, output ready);
endinterface

>>> rtl/cwpg_rsp_if.sv
interface cwpg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [cwpg_pkg::INDEX_BITS-1:0]     first_index;
   logic [cwpg_pkg::INDEX_BITS-1:0]     second_index;
   logic signed [cwpg_pkg::DIST_BITS-1:0] distance;
   logic                                last_pair;

   modport source (output valid, output first_index, output second_index,
                   output distance, output last_pair, input ready);
   modport sink (input valid, input first_index, input second_index,
                 input distance, input last_pair, output ready);
endinterface

>>> rtl/cwpg_front.sv
module cwpg_front (
   input  logic                                 clock,
   input  logic                                 reset,
   cwpg_req_if.sink                             req_port,
   input  logic                                 csr_write_enable,
   input  logic [cwpg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cwpg_pkg::WINDOW_BITS-1:0]     csr_write_data,
   output logic                                 push_valid,
   output cwpg_pkg::job_type                    push_job,
   input  logic                                 push_ready
);

   cwpg_pkg::window_type window_left_ff, window_left_in;
   cwpg_pkg::window_type window_right_ff, window_right_in;
   cwpg_pkg::window_type fill_ff, fill_in;
   cwpg_pkg::window_type win_left, win_right, win_max, fill_next;
   logic                 accept;

   // saturate windows above the history depth
   always_comb begin
      win_left  = (window_left_ff > cwpg_pkg::MAX_WINDOW) ? cwpg_pkg::MAX_WINDOW
                                                          : window_left_ff;
      win_right = (window_right_ff > cwpg_pkg::MAX_WINDOW) ? cwpg_pkg::MAX_WINDOW
                                                           : window_right_ff;
      win_max   = (win_left > win_right) ? win_left : win_right;
      fill_next = fill_ff + 4'd1;
   end

   assign req_port.ready = push_ready;
   assign accept         = req_port.valid && push_ready;
   assign push_valid     = req_port.valid;

   always_comb begin
      push_job.word       = req_port.word_index;
      push_job.start_dist = (fill_ff < win_max) ? fill_ff : win_max;
      push_job.win_left   = win_left;
      push_job.win_right  = win_right;
   end

   always_comb begin
      window_left_in  = window_left_ff;
      window_right_in = window_right_ff;
      fill_in         = fill_ff;
      if (csr_write_enable) begin
         case (csr_index)
            cwpg_pkg::CSR_WINDOW_LEFT:  window_left_in  = csr_write_data;
            cwpg_pkg::CSR_WINDOW_RIGHT: window_right_in = csr_write_data;
            default: ;
         endcase
      end
      if (accept && (fill_next <= win_max)) begin
         fill_in = fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_left_ff  <= cwpg_pkg::WINDOW_RESET;
         window_right_ff <= cwpg_pkg::WINDOW_RESET;
         fill_ff         <= '0;
      end else begin
         window_left_ff  <= window_left_in;
         window_right_ff <= window_right_in;
         fill_ff         <= fill_in;
      end
   end

endmodule

>>> rtl/cwpg_queue.sv
module cwpg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  cwpg_pkg::job_type push_job,
   output logic              push_ready,
   output logic              pop_valid,
   output cwpg_pkg::job_type pop_job,
   input  logic              pop
);

   cwpg_pkg::job_type                     entry_ff [cwpg_pkg::QUEUE_DEPTH];
   logic [cwpg_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [cwpg_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [cwpg_pkg::QUEUE_CNT_BITS-1:0]   count_ff, count_in;
   logic                                  do_push, do_pop;

   assign push_ready = (count_ff != cwpg_pkg::QUEUE_CNT_BITS'(cwpg_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/cwpg_back.sv
module cwpg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  cwpg_pkg::job_type pop_job,
   output logic              pop,
   cwpg_rsp_if.source        rsp_port
);

   cwpg_pkg::back_state_type state_ff, state_in;

   logic [cwpg_pkg::INDEX_BITS-1:0]     hist_ff [cwpg_pkg::HIST_DEPTH];
   logic [cwpg_pkg::HIST_PTR_BITS-1:0]  head_ff, head_in;
   logic [cwpg_pkg::INDEX_BITS-1:0]     word_ff, word_in;
   cwpg_pkg::window_type                win_left_ff, win_left_in;
   cwpg_pkg::window_type                win_right_ff, win_right_in;
   cwpg_pkg::window_type                dist_ff, dist_in;
   logic                                neg_ff, neg_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [cwpg_pkg::INDEX_BITS-1:0]     first_ff, first_in;
   logic [cwpg_pkg::INDEX_BITS-1:0]     second_ff, second_in;
   logic signed [cwpg_pkg::DIST_BITS-1:0] distance_ff, distance_in;
   logic                                last_ff, last_in;

   logic [cwpg_pkg::HIST_PTR_BITS-1:0]  slot;
   logic [cwpg_pkg::INDEX_BITS-1:0]     prev;
   logic [cwpg_pkg::DIST_BITS-1:0]      dist_wide;
   cwpg_pkg::window_type                dist_down;
   logic                                out_free, is_last, hist_write;

   // distance of eight wraps onto the head slot itself
   assign slot      = head_ff - dist_ff[cwpg_pkg::HIST_PTR_BITS-1:0];
   assign prev      = hist_ff[slot];
   assign dist_wide = {1'b0, dist_ff};
   assign dist_down = dist_ff - 4'd1;
   assign out_free  = !rsp_valid_ff || rsp_port.ready;
   assign is_last   = (dist_ff == 4'd1) && (neg_ff || (win_left_ff == '0));

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      word_in      = word_ff;
      win_left_in  = win_left_ff;
      win_right_in = win_right_ff;
      dist_in      = dist_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      first_in     = first_ff;
      second_in    = second_ff;
      distance_in  = distance_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      hist_write   = 1'b0;
      case (state_ff)
         cwpg_pkg::BACK_IDLE: begin
            if (pop_valid) begin
               pop          = 1'b1;
               word_in      = pop_job.word;
               win_left_in  = pop_job.win_left;
               win_right_in = pop_job.win_right;
               dist_in      = pop_job.start_dist;
               neg_in       = !(pop_job.start_dist <= pop_job.win_right);
               if (pop_job.start_dist == '0) begin
                  // no pairs, the word only enters the history
                  hist_write = 1'b1;
                  head_in    = head_ff + 1'b1;
               end else begin
                  state_in = cwpg_pkg::BACK_EMIT;
               end
            end
         end
         cwpg_pkg::BACK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               last_in      = is_last;
               if (neg_ff) begin
                  first_in    = word_ff;
                  second_in   = prev;
                  distance_in = -$signed(dist_wide);
               end else begin
                  first_in    = prev;
                  second_in   = word_ff;
                  distance_in = $signed(dist_wide);
               end
               if (is_last) begin
                  hist_write = 1'b1;
                  head_in    = head_ff + 1'b1;
                  state_in   = cwpg_pkg::BACK_IDLE;
               end else if (!neg_ff && (dist_ff <= win_left_ff)) begin
                  neg_in = 1'b1;
               end else begin
                  dist_in = dist_down;
                  neg_in  = !(dist_down <= win_right_ff);
               end
            end
         end
         default: state_in = cwpg_pkg::BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cwpg_pkg::BACK_IDLE;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      win_left_ff  <= win_left_in;
      win_right_ff <= win_right_in;
      dist_ff      <= dist_in;
      neg_ff       <= neg_in;
      first_ff     <= first_in;
      second_ff    <= second_in;
      distance_ff  <= distance_in;
      last_ff      <= last_in;
      // word_in is the popped word in idle and the held word in emit
      if (hist_write) begin
         hist_ff[head_ff] <= word_in;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.first_index  = first_ff;
   assign rsp_port.second_index = second_ff;
   assign rsp_port.distance     = distance_ff;
   assign rsp_port.last_pair    = last_ff;

endmodule

>>> rtl/context_window_pair_generator.sv
// context window pair generator, skip-gram style
// req_port carries one word index per request; rsp_port returns the context
// pairs it causes: for each remembered word, oldest first, (prev, cur, +d) when
// d is within window_right, then (cur, prev, -d) when d is within window_left.
// last_pair marks the final pair of a word; a word with no pairs gives nothing.
// csr_index 0 writes window_left, 1 writes window_right (values above 8 act as
// 8); other indexes are ignored. write the windows only while the block is idle.
// a word enters a two-deep job queue at the accepting edge; the back end pops
// it from the queue while idle, loads it, and registers each of its pairs in
// the output register; further pairs follow one per cycle unless output stalls.
// the single pair emitter in the back end takes one word at a time and pops
// the next one only once the current word has sent its last pair.
// reset: windows return to 4, the history is empty, queue and output clear.
// a stalled receiver holds the output register; the emitter waits, the queue
// fills and req_port.ready drops once both queue slots are taken.
module context_window_pair_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   cwpg_req_if.sink                             req_port,
   cwpg_rsp_if.source                           rsp_port,
   input  logic                                 csr_write_enable,
   input  logic [cwpg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cwpg_pkg::WINDOW_BITS-1:0]     csr_write_data
);

   // front to queue
   logic              push_valid;
   logic              push_ready;
   cwpg_pkg::job_type push_job;

   // queue to back
   logic              pop_valid;
   logic              pop;
   cwpg_pkg::job_type pop_job;

   // front: window registers, history fill tracking, classification
   cwpg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_port),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_job         (push_job),
      .push_ready       (push_ready)
   );

   // short job queue decoupling acceptance from pair emission
   cwpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop)
   );

   // back: history ring, pair sequencer and output register
   cwpg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop       (pop),
      .rsp_port  (rsp_port)
   );

endmodule

>>> verif/context_window_pair_generator_tb.sv
module context_window_pair_generator_tb;

   // register indexes that the block does not decode, writes must be dropped
   localparam cwpg_pkg::csr_index_type CSR_SPARE_LOW  = 2'd2;
   localparam cwpg_pkg::csr_index_type CSR_SPARE_HIGH = 2'd3;

   // cycles allowed after the last pair for words that cause none
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_WORDS  = 22;

   typedef struct packed {
      logic [cwpg_pkg::INDEX_BITS-1:0]        first_index;
      logic [cwpg_pkg::INDEX_BITS-1:0]        second_index;
      logic signed [cwpg_pkg::DIST_BITS-1:0]  distance;
      logic                                   last_pair;
   } context_pair_type;

   // mirrors window registers and word history, holds the pairs still owed
   class pair_scoreboard;
      cwpg_pkg::window_type            left_win;
      cwpg_pkg::window_type            right_win;
      logic [cwpg_pkg::INDEX_BITS-1:0] recent[cwpg_pkg::HIST_DEPTH];
      int                              fill;
      int                              head;
      context_pair_type                pairs_due[$];
      int                              errors;

      function new();
         left_win  = cwpg_pkg::WINDOW_RESET;
         right_win = cwpg_pkg::WINDOW_RESET;
         fill      = 0;
         head      = 0;
         errors    = 0;
      endfunction

      function void write_window(cwpg_pkg::csr_index_type idx,
                                 cwpg_pkg::window_type value);
         if (idx == cwpg_pkg::CSR_WINDOW_LEFT) begin
            left_win = value;
         end else if (idx == cwpg_pkg::CSR_WINDOW_RIGHT) begin
            right_win = value;
         end
      endfunction

      function void owe_pair(context_pair_type p);
         pairs_due.insert(pairs_due.size(), p);
      endfunction

      // accepted request: queue every context pair this word causes
      function void take_word(logic [cwpg_pkg::INDEX_BITS-1:0] word);
         int               wl;
         int               wr;
         int               reach;
         int               produced;
         int               slot;
         context_pair_type p;
         wl       = (left_win > cwpg_pkg::MAX_WINDOW) ? int'(cwpg_pkg::MAX_WINDOW)
                                                      : int'(left_win);
         wr       = (right_win > cwpg_pkg::MAX_WINDOW) ? int'(cwpg_pkg::MAX_WINDOW)
                                                       : int'(right_win);
         reach    = (wl > wr) ? wl : wr;
         produced = 0;
         for (int d = fill; d >= 1; d--) begin
            slot = (head + cwpg_pkg::HIST_DEPTH - d) % cwpg_pkg::HIST_DEPTH;
            if (d <= wr) begin
               p.first_index  = recent[slot];
               p.second_index = word;
               p.distance     = cwpg_pkg::DIST_BITS'(d);
               p.last_pair    = 1'b0;
               owe_pair(p);
               produced++;
            end
            if (d <= wl) begin
               p.first_index  = word;
               p.second_index = recent[slot];
               p.distance     = cwpg_pkg::DIST_BITS'(-d);
               p.last_pair    = 1'b0;
               owe_pair(p);
               produced++;
            end
         end
         if (produced > 0) begin
            pairs_due[pairs_due.size()-1].last_pair = 1'b1;
         end
         recent[head] = word;
         head = (head + 1) % cwpg_pkg::HIST_DEPTH;
         if (fill + 1 <= reach) begin
            fill++;
         end
      endfunction

      function void check_pair(context_pair_type got);
         context_pair_type want;
         if (pairs_due.size() == 0) begin
            $error("unexpected pair: first %h second %h distance %0d last %b",
                   got.first_index, got.second_index, got.distance, got.last_pair);
            errors++;
            return;
         end
         want = pairs_due.pop_front();
         if (got.first_index !== want.first_index) begin
            $error("first_index: expected %h, actual %h", want.first_index, got.first_index);
            errors++;
         end
         if (got.second_index !== want.second_index) begin
            $error("second_index: expected %h, actual %h", want.second_index,
                   got.second_index);
            errors++;
         end
         if (got.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, got.distance);
            errors++;
         end
         if (got.last_pair !== want.last_pair) begin
            $error("last_pair: expected %b, actual %b", want.last_pair, got.last_pair);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   cwpg_pkg::csr_index_type   csr_index;
   cwpg_pkg::window_type      csr_write_data;

   // percent of cycles the sender holds back and the receiver stalls
   int                        idle_pct;
   int                        stall_pct;
   pair_scoreboard            sb;
   context_pair_type          seen_pair;

   cwpg_req_if req_bus();
   cwpg_rsp_if rsp_bus();

   context_window_pair_generator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // receiver: check each accepted pair, then pick next cycle's ready
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            seen_pair.first_index  = rsp_bus.first_index;
            seen_pair.second_index = rsp_bus.second_index;
            seen_pair.distance     = rsp_bus.distance;
            seen_pair.last_pair    = rsp_bus.last_pair;
            sb.check_pair(seen_pair);
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // one request: optional idle cycles, then hold valid until ready
   task automatic send_word(input logic [cwpg_pkg::INDEX_BITS-1:0] word);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.word_index <= word;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.take_word(word);
   endtask

   // stop requesting, let every owed pair out, then allow for silent words
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (sb.pairs_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // csr write: pulse the strobe with index and data, the trailing cycle keeps strobes apart
   task automatic csr_write(input cwpg_pkg::csr_index_type idx,
                            input cwpg_pkg::window_type value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.write_window(idx, value);
      @(posedge clock);
   endtask

   function automatic logic [cwpg_pkg::INDEX_BITS-1:0] rand_word();
      case ($urandom_range(7))
         0:       rand_word = '0;
         1:       rand_word = '1;
         2:       rand_word = cwpg_pkg::INDEX_BITS'($urandom_range(15));
         default: rand_word = cwpg_pkg::INDEX_BITS'($urandom());
      endcase
   endfunction

   // favor the edges: zero, full window and values that saturate
   function automatic cwpg_pkg::window_type rand_window();
      case ($urandom_range(5))
         0:       rand_window = '0;
         1:       rand_window = cwpg_pkg::MAX_WINDOW;
         2:       rand_window = '1;
         default: rand_window = cwpg_pkg::window_type'($urandom_range(15));
      endcase
   endfunction

   initial begin
      sb = new();
      idle_pct  = 0;
      stall_pct = 0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.word_index <= '0;
      csr_write_enable   <= 1'b0;
      csr_index          <= cwpg_pkg::CSR_WINDOW_LEFT;
      csr_write_data     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset windows, first word has no history so no pairs
      send_word('0);
      send_word('1);
      send_word(28'hAAAAAAA);
      send_word(28'h5555555);
      send_word(28'h0000001);
      send_word(28'h8000000);
      wait_idle();

      // values above the limit act as full window
      csr_write(cwpg_pkg::CSR_WINDOW_LEFT, '1);
      csr_write(cwpg_pkg::CSR_WINDOW_RIGHT, 4'd9);
      send_word(28'h1234567);
      send_word(28'hFEDCBA9);
      send_word(28'h0F0F0F0);
      wait_idle();

      // shrinking windows keep the history length
      csr_write(cwpg_pkg::CSR_WINDOW_LEFT, '0);
      csr_write(cwpg_pkg::CSR_WINDOW_RIGHT, 4'd2);
      send_word(28'h7FFFFFF);
      send_word(28'h0000002);
      wait_idle();

      // both windows closed: silent words, history fill frozen, words still enter the history
      csr_write(cwpg_pkg::CSR_WINDOW_RIGHT, '0);
      send_word(28'h3333333);
      send_word(28'hCCCCCCC);
      wait_idle();

      // undecoded indexes must not touch the windows
      csr_write(CSR_SPARE_LOW, '1);
      csr_write(CSR_SPARE_HIGH, '1);
      send_word(28'h0000003);
      wait_idle();

      // left only
      csr_write(cwpg_pkg::CSR_WINDOW_LEFT, cwpg_pkg::MAX_WINDOW);
      send_word(28'h0000004);
      send_word(28'h0000005);
      send_word(28'hFFFFFFE);
      wait_idle();

      // random phases, rotating through the idle/stall mixes
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 56; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 56; end
            default: begin idle_pct = 13; stall_pct = 13; end
         endcase
         if (phase == 0) begin
            csr_write(cwpg_pkg::CSR_WINDOW_LEFT, cwpg_pkg::MAX_WINDOW);
            csr_write(cwpg_pkg::CSR_WINDOW_RIGHT, cwpg_pkg::MAX_WINDOW);
         end else begin
            csr_write(cwpg_pkg::CSR_WINDOW_LEFT, rand_window());
            csr_write(cwpg_pkg::CSR_WINDOW_RIGHT, rand_window());
            if (phase == 5) begin
               csr_write(CSR_SPARE_HIGH, cwpg_pkg::window_type'($urandom_range(15)));
            end
         end
         for (int k = 0; k < PHASE_WORDS; k++) begin
            send_word(rand_word());
         end
         wait_idle();
      end

      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
